[rtl/core/qpn_pkg.sv]
// Shared widths and the payload type for the normalized quaternion product unit.
package qpn_pkg;

  localparam int unsigned CompW   = 16;
  localparam int unsigned NumComp = 4;
  localparam int unsigned InDataW  = 2 * NumComp * CompW;
  localparam int unsigned OutDataW = NumComp * CompW;
  localparam int unsigned SqrtSteps = 32;

  typedef struct packed {
    logic [NumComp-1:0][30:0] u;
    logic [NumComp-1:0]       neg;
    logic                     zero;
  } lane_pay_t;

endpackage

[rtl/core/quaternion_product_normalized_unit.sv]
// Normalized Hamilton quaternion product unit, deep pipeline top level.
//
// The slave channel takes one request per cycle unless the receiver stalls:
// s_tdata_i packs left x, y, z, w and right x, y, z, w as signed Q1.14 words,
// lowest bits first. The master channel returns the normalized product x, y,
// z, w in m_tdata_o and the zero magnitude flag in m_tuser_o. A zero product
// gives all zero words with the flag set.
// Throughput is one request per cycle unless the receiver stalls; the
// pipeline has seven arithmetic stages, thirty-two square root digit stages,
// one divider setup stage and FRAC_BITS + 1 divider stages, followed by the
// output register.
// When the receiver stalls with a result waiting, every stage holds and
// s_tready_o drops, so nothing is lost or repeated. Reset clears all valid
// bits; the data registers are not reset.
module quaternion_product_normalized_unit #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // left_x, left_y, left_z, left_w, right_x, right_y, right_z, right_w.
  input  logic [qpn_pkg::InDataW-1:0]   s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // prod_x, prod_y, prod_z, prod_w.
  output logic [qpn_pkg::OutDataW-1:0]  m_tdata_o,
  // zero_magnitude.
  output logic                          m_tuser_o
);
  import qpn_pkg::*;

  localparam int unsigned Nst = FRAC_BITS + 42;
  localparam int unsigned Dw  = 33 + FRAC_BITS;
  localparam int unsigned Qw  = FRAC_BITS + 1;

  logic           en;
  logic [Nst-1:0] vld_q;

  assign en         = m_tready_i | ~vld_q[Nst-1];
  assign s_tready_o = en;
  assign m_tvalid_o = vld_q[Nst-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Nst-2:0], s_tvalid_i};
    end
  end

  // Stage 1: partial products.
  logic signed [CompW-1:0] lc [NumComp];
  logic signed [CompW-1:0] rc [NumComp];
  logic signed [31:0]      prd_q [16];

  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      lc[i] = s_tdata_i[CompW*i +: CompW];
      rc[i] = s_tdata_i[CompW*(i+NumComp) +: CompW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prd_q[0]  <= lc[3] * rc[0];
      prd_q[1]  <= lc[0] * rc[3];
      prd_q[2]  <= lc[1] * rc[2];
      prd_q[3]  <= lc[2] * rc[1];
      prd_q[4]  <= lc[3] * rc[1];
      prd_q[5]  <= lc[1] * rc[3];
      prd_q[6]  <= lc[2] * rc[0];
      prd_q[7]  <= lc[0] * rc[2];
      prd_q[8]  <= lc[3] * rc[2];
      prd_q[9]  <= lc[2] * rc[3];
      prd_q[10] <= lc[0] * rc[1];
      prd_q[11] <= lc[1] * rc[0];
      prd_q[12] <= lc[3] * rc[3];
      prd_q[13] <= lc[0] * rc[0];
      prd_q[14] <= lc[1] * rc[1];
      prd_q[15] <= lc[2] * rc[2];
    end
  end

  // Stage 2: product components.
  logic signed [33:0] p_q [NumComp];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= 34'(prd_q[4*i]) + 34'(prd_q[4*i+1]) + 34'(prd_q[4*i+2])
                - 34'(prd_q[4*i+3]);
      end
      p_q[3] <= 34'(prd_q[12]) - 34'(prd_q[13]) - 34'(prd_q[14]) - 34'(prd_q[15]);
    end
  end

  // Stage 3: magnitudes and their maximum.
  logic [32:0]        ab_d [NumComp];
  logic [32:0]        u3_q [NumComp];
  logic [NumComp-1:0] neg3_q;
  logic [32:0]        m3_d, m3_q;

  always_comb begin
    m3_d = '0;
    for (int i = 0; i < NumComp; i++) begin
      ab_d[i] = p_q[i][33] ? 33'(-p_q[i]) : 33'(p_q[i]);
      if (ab_d[i] > m3_d) begin
        m3_d = ab_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumComp; i++) begin
        u3_q[i]   <= ab_d[i];
        neg3_q[i] <= p_q[i][33];
      end
      m3_q <= m3_d;
    end
  end

  // Stage 4: leading one position of the maximum.
  logic [5:0]         pos4_d, pos4_q;
  logic [32:0]        u4_q [NumComp];
  logic [NumComp-1:0] neg4_q;
  logic               zero4_q;

  always_comb begin
    pos4_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (m3_q[i]) begin
        pos4_d = 6'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos4_q  <= pos4_d;
      u4_q    <= u3_q;
      neg4_q  <= neg3_q;
      zero4_q <= (m3_q == '0);
    end
  end

  // Stage 5: block scaling so the maximum lies in [2^30, 2^31).
  logic [30:0]        un5_d [NumComp];
  logic [63:0]        shl_d [NumComp];
  logic [30:0]        un5_q [NumComp];
  logic [NumComp-1:0] neg5_q;
  logic               zero5_q;

  always_comb begin
    for (int i = 0; i < NumComp; i++) begin
      shl_d[i] = 64'(u4_q[i]) << (6'd30 - pos4_q);
      if (pos4_q >= 6'd31) begin
        un5_d[i] = 31'(u4_q[i] >> (pos4_q - 6'd30));
      end else begin
        un5_d[i] = shl_d[i][30:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      un5_q   <= un5_d;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  // Stage 6: squares.
  logic [61:0]        sq6_q [NumComp];
  logic [30:0]        un6_q [NumComp];
  logic [NumComp-1:0] neg6_q;
  logic               zero6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumComp; i++) begin
        sq6_q[i] <= un5_q[i] * un5_q[i];
      end
      un6_q   <= un5_q;
      neg6_q  <= neg5_q;
      zero6_q <= zero5_q;
    end
  end

  // Stage 7: sum of squares.
  logic [63:0] sr_q   [SqrtSteps+1];
  logic [64:0] root_q [SqrtSteps+1];
  lane_pay_t   spl_q  [SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q[0]   <= 64'(sq6_q[0]) + 64'(sq6_q[1]) + 64'(sq6_q[2]) + 64'(sq6_q[3]);
      root_q[0] <= '0;
      for (int i = 0; i < NumComp; i++) begin
        spl_q[0].u[i] <= un6_q[i];
      end
      spl_q[0].neg  <= neg6_q;
      spl_q[0].zero <= zero6_q;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [64:0] Bit = 65'(1) << (2 * (SqrtSteps - 1 - k));
    logic [64:0] trial;

    assign trial = root_q[k] + Bit;

    always_ff @(posedge clk_i) begin
      if (en) begin
        spl_q[k+1] <= spl_q[k];
        if ({1'b0, sr_q[k]} >= trial) begin
          sr_q[k+1]   <= sr_q[k] - trial[63:0];
          root_q[k+1] <= (root_q[k] >> 1) + Bit;
        end else begin
          sr_q[k+1]   <= sr_q[k];
          root_q[k+1] <= root_q[k] >> 1;
        end
      end
    end
  end

  // Rounded division of each scaled magnitude by the root.
  logic [31:0]   qv;
  logic [Dw-1:0] dr_q   [Qw+1][NumComp];
  logic [Qw-1:0] quot_q [Qw+1][NumComp];
  logic [31:0]   dq_q   [Qw+1];
  lane_pay_t     dpl_q  [Qw+1];

  assign qv = root_q[SqrtSteps][31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumComp; i++) begin
        dr_q[0][i]   <= (Dw'(spl_q[SqrtSteps].u[i]) << FRAC_BITS) + Dw'(qv[31:1]);
        quot_q[0][i] <= '0;
      end
      dq_q[0]  <= qv;
      dpl_q[0] <= spl_q[SqrtSteps];
    end
  end

  for (genvar j = 0; j < Qw; j++) begin : g_div
    localparam int unsigned K = FRAC_BITS - j;
    logic [Dw-1:0] dsh;

    assign dsh = Dw'(dq_q[j]) << K;

    always_ff @(posedge clk_i) begin
      if (en) begin
        dq_q[j+1]  <= dq_q[j];
        dpl_q[j+1] <= dpl_q[j];
        for (int i = 0; i < NumComp; i++) begin
          if (dr_q[j][i] >= dsh) begin
            dr_q[j+1][i]   <= dr_q[j][i] - dsh;
            quot_q[j+1][i] <= quot_q[j][i] | (Qw'(1) << K);
          end else begin
            dr_q[j+1][i]   <= dr_q[j][i];
            quot_q[j+1][i] <= quot_q[j][i];
          end
        end
      end
    end
  end

  // Output register: clamp, sign and pack.
  localparam logic [Qw-1:0] One = Qw'(1) << FRAC_BITS;

  logic [Qw-1:0]       mag_d [NumComp];
  logic [31:0]         sgn_d [NumComp];
  logic [OutDataW-1:0] data_d, data_q;
  logic                zero_q;

  always_comb begin
    data_d = '0;
    for (int i = 0; i < NumComp; i++) begin
      mag_d[i] = (quot_q[Qw][i] > One) ? One : quot_q[Qw][i];
      sgn_d[i] = dpl_q[Qw].neg[i] ? (32'd0 - 32'(mag_d[i])) : 32'(mag_d[i]);
      if (!dpl_q[Qw].zero) begin
        data_d[CompW*i +: CompW] = sgn_d[i][CompW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      zero_q <= dpl_q[Qw].zero;
    end
  end

  assign m_tdata_o = data_q;
  assign m_tuser_o = zero_q;

endmodule

[rtl/core/qpn_checker.sv]
// Port-level checker for the normalized quaternion product unit, with its bind.
module qpn_checker #(
  parameter int unsigned FRAC_BITS = 14
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tready_o,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [qpn_pkg::OutDataW-1:0]  m_tdata_o,
  input logic                          m_tuser_o
);
  import qpn_pkg::*;

  localparam logic signed [CompW:0] Lim = (CompW+1)'(1) << FRAC_BITS;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("stalled result changed");

  // The pipeline advances exactly when the output can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o == (m_tready_i || !m_tvalid_o))
    else $error("ready does not follow the output stall");

  // A zero product gives all zero components.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tdata_o == '0)
    else $error("zero magnitude result has nonzero data");

  // When FRAC_BITS is at most 14, a nonzero product gives unit-range components, not all zero.
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o && (FRAC_BITS <= 14) |->
      m_tdata_o != '0 &&
      $signed(m_tdata_o[15:0]) <= Lim && $signed(m_tdata_o[15:0]) >= -Lim &&
      $signed(m_tdata_o[31:16]) <= Lim && $signed(m_tdata_o[31:16]) >= -Lim &&
      $signed(m_tdata_o[47:32]) <= Lim && $signed(m_tdata_o[47:32]) >= -Lim &&
      $signed(m_tdata_o[63:48]) <= Lim && $signed(m_tdata_o[63:48]) >= -Lim)
    else $error("normalized component out of range");

endmodule

bind quaternion_product_normalized_unit qpn_checker #(.FRAC_BITS(FRAC_BITS)) u_qpn_checker (.*);
